FILE: hdl/dwt_pkg.sv
// Shared constants and types for the differential wrist transform.
// Used by dwt_front, dwt_div_lane and the top level differential_wrist_transform.
package dwt_pkg;

  localparam int FRAC_BITS = 16;

  // Input and result widths.
  localparam int IW = 32;
  localparam int VW = IW + 1;

  // Quotient of a scaled value: magnitude never exceeds 1.0, so one integer bit.
  localparam int QW = FRAC_BITS + 1;

  // Divider stages in one lane, one quotient bit per stage.
  localparam int NSTG = QW;

  // Pipeline: two front stages, the divider stages, one output stage.
  localparam int NFRONT = 2;
  localparam int NPIPE  = NFRONT + NSTG + 1;

  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  typedef logic [1:0] mode_t;

  // Mode codes and the bits that select them.
  localparam mode_t MODE_G2J_POS = 2'd0;
  localparam mode_t MODE_J2G_POS = 2'd1;
  localparam mode_t MODE_G2J_PWR = 2'd2;
  localparam mode_t MODE_J2G_PWR = 2'd3;
  localparam int MODE_J2G_BIT = 0;
  localparam int MODE_PWR_BIT = 1;

  typedef struct packed {
    logic [VW-1:0] val;
    logic [VW-1:0] mag;
    logic          neg;
    logic          scl;
  } lane_in_t;

  typedef struct packed {
    logic [VW-1:0] res;
    logic          scl;
  } lane_out_t;

endpackage

FILE: hdl/differential_wrist_transform.sv
// Top level of the differential wrist transform: handshake control, lanes, result merge.
// Depends on dwt_pkg, dwt_front and dwt_div_lane.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_mode, in_first_in, in_second_in
//   out_     output     out_valid/out_stall  out_first_out, out_second_out, out_was_scaled
//
// One item per cycle is accepted unless out_stall has backed the pipeline up to the input; in Q16.16
// the divider lanes resolve one quotient bit per stage.
// Every stage has its own valid bit and fills when empty or when the stage after it moves,
// so bubbles close up and input still fills empty stages while the output is stalled.
// Synchronous active-low reset clears only the valid bits.
module differential_wrist_transform
  import dwt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mode_t                in_mode,
  input  logic signed [IW-1:0] in_first_in,
  input  logic signed [IW-1:0] in_second_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [VW-1:0] out_first_out,
  output logic signed [VW-1:0] out_second_out,
  output logic                 out_was_scaled
);

  logic [NPIPE-1:0] vld_r, vld_nxt;
  logic [NPIPE-1:0] adv;

  always_comb begin
    adv[NPIPE-1] = !vld_r[NPIPE-1] || !out_stall;
    for (int i = NPIPE - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    for (int i = 0; i < NPIPE; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i - 1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NPIPE-1];

  lane_in_t      li0, li1;
  logic [VW-1:0] dvs;
  lane_out_t     lo0, lo1;

  dwt_front u_front (
    .clk        (clk),
    .en         (adv[NFRONT-1:0]),
    .mode       (in_mode),
    .first_val  (in_first_in),
    .second_val (in_second_in),
    .lane0      (li0),
    .lane1      (li1),
    .dvs        (dvs)
  );

  dwt_div_lane u_lane0 (
    .clk (clk),
    .en  (adv[NFRONT+NSTG-1:NFRONT]),
    .li  (li0),
    .dvs (dvs),
    .lo  (lo0)
  );

  dwt_div_lane u_lane1 (
    .clk (clk),
    .en  (adv[NFRONT+NSTG-1:NFRONT]),
    .li  (li1),
    .dvs (dvs),
    .lo  (lo1)
  );

  logic [VW-1:0] first_r, second_r;
  logic          scaled_r;

  // Both lanes carry the same scaling decision; the flag is the AND of the two.
  always_ff @(posedge clk) begin
    if (adv[NPIPE-1]) begin
      first_r  <= lo0.res;
      second_r <= lo1.res;
      scaled_r <= lo0.scl && lo1.scl;
    end
  end

  assign out_first_out  = $signed(first_r);
  assign out_second_out = $signed(second_r);
  assign out_was_scaled = scaled_r;

endmodule

FILE: hdl/dwt_front.sv
// Front end: gear/joint butterfly, then magnitudes, maximum and the scaling decision.
// Depends on dwt_pkg.
module dwt_front
  import dwt_pkg::*;
(
  input  logic                 clk,
  input  logic [NFRONT-1:0]    en,
  input  mode_t                mode,
  input  logic signed [IW-1:0] first_val,
  input  logic signed [IW-1:0] second_val,
  output lane_in_t             lane0,
  output lane_in_t             lane1,
  output logic [VW-1:0]        dvs
);

  logic [VW-1:0] a_ext, b_ext, sum, dif_ab, dif_ba;
  logic [VW-1:0] r0_nxt, r1_nxt;
  logic [VW-1:0] r0_r, r1_r;
  logic          pwr_r;

  logic [VW-1:0] mag0, mag1, mx;
  logic          scl;
  lane_in_t      lane0_nxt, lane1_nxt;
  lane_in_t      lane0_r, lane1_r;
  logic [VW-1:0] dvs_r;

  always_comb begin
    a_ext  = {first_val[IW-1], first_val};
    b_ext  = {second_val[IW-1], second_val};
    sum    = a_ext + b_ext;
    dif_ab = a_ext - b_ext;
    dif_ba = b_ext - a_ext;
    if (mode[MODE_J2G_BIT]) begin
      r0_nxt = dif_ab;
      r1_nxt = sum;
    end else begin
      // Halving rounds toward minus infinity: an arithmetic shift right.
      r0_nxt = {sum[VW-1], sum[VW-1:1]};
      r1_nxt = {dif_ba[VW-1], dif_ba[VW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r0_r  <= r0_nxt;
      r1_r  <= r1_nxt;
      pwr_r <= mode[MODE_PWR_BIT];
    end
  end

  always_comb begin
    // The most negative value negates to 2^32, which still fits unsigned.
    mag0 = r0_r[VW-1] ? (~r0_r + VW'(1)) : r0_r;
    mag1 = r1_r[VW-1] ? (~r1_r + VW'(1)) : r1_r;
    mx   = (mag0 > mag1) ? mag0 : mag1;
    scl  = pwr_r && (mx > ONE);
    lane0_nxt = '{val: r0_r, mag: mag0, neg: r0_r[VW-1], scl: scl};
    lane1_nxt = '{val: r1_r, mag: mag1, neg: r1_r[VW-1], scl: scl};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lane0_r <= lane0_nxt;
      lane1_r <= lane1_nxt;
      dvs_r   <= mx;
    end
  end

  assign lane0 = lane0_r;
  assign lane1 = lane1_r;
  assign dvs   = dvs_r;

endmodule

FILE: hdl/dwt_div_lane.sv
// One lane of the pipelined restoring divider: value * 2^FRAC_BITS / max; unscaled values pass through.
// Depends on dwt_pkg.
module dwt_div_lane
  import dwt_pkg::*;
(
  input  logic             clk,
  input  logic [NSTG-1:0]  en,
  input  lane_in_t         li,
  input  logic [VW-1:0]    dvs,
  output lane_out_t        lo
);

  logic [VW-1:0] rem_r [NSTG];
  logic [QW-1:0] q_r   [NSTG];
  logic [VW-1:0] d_r   [NSTG];
  logic [VW-1:0] val_r [NSTG];
  logic          neg_r [NSTG];
  logic          scl_r [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    // Index of the stage ahead of this one; the first stage takes the lane input instead.
    localparam int PK = (k == 0) ? 0 : k - 1;

    logic [VW:0]   t;
    logic [VW-1:0] d_in, val_in;
    logic [QW-1:0] q_in;
    logic          neg_in, scl_in, ge;
    logic [VW:0]   diff;
    logic [VW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    always_comb begin
      if (k == 0) begin
        // The first bit has weight 1.0, and the magnitude never exceeds the max.
        t      = {1'b0, li.mag};
        d_in   = dvs;
        q_in   = '0;
        val_in = li.val;
        neg_in = li.neg;
        scl_in = li.scl;
      end else begin
        t      = {rem_r[PK], 1'b0};
        d_in   = d_r[PK];
        q_in   = q_r[PK];
        val_in = val_r[PK];
        neg_in = neg_r[PK];
        scl_in = scl_r[PK];
      end
      diff    = t - {1'b0, d_in};
      ge      = (t >= {1'b0, d_in});
      rem_nxt = ge ? diff[VW-1:0] : t[VW-1:0];
      q_nxt   = {q_in[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        d_r[k]   <= d_in;
        val_r[k] <= val_in;
        neg_r[k] <= neg_in;
        scl_r[k] <= scl_in;
      end
    end
  end

  logic [VW-1:0] q_ext;

  always_comb begin
    q_ext = {{(VW-QW){1'b0}}, q_r[NSTG-1]};
    // The quotient truncates toward zero, so the sign is applied afterwards.
    if (scl_r[NSTG-1]) begin
      lo.res = neg_r[NSTG-1] ? (~q_ext + VW'(1)) : q_ext;
    end else begin
      lo.res = val_r[NSTG-1];
    end
    lo.scl = scl_r[NSTG-1];
  end

endmodule

FILE: sim/differential_wrist_transform_test.sv
// Self-checking testbench for differential_wrist_transform: directed corner items, then
// random position and power pairs, checked against an in-line predictor of the transform.
// Depends on dwt_pkg and the RTL of differential_wrist_transform.
module differential_wrist_transform_test;
  import dwt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VW-1:0] first;
    logic signed [VW-1:0] second;
    logic                 scaled;
  } wrist_pair_t;

  localparam int UNITY = 1 << FRAC_BITS;
  localparam int IMAX  = 32'h7fff_ffff;
  localparam int IMIN  = 32'h8000_0000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  mode_t                in_mode = MODE_G2J_POS;
  logic signed [IW-1:0] in_first_in = '0;
  logic signed [IW-1:0] in_second_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [VW-1:0] out_first_out;
  logic signed [VW-1:0] out_second_out;
  logic                 out_was_scaled;

  wrist_pair_t pending_pairs[$];
  int          error_count = 0;
  bit          steady_flow = 1'b0;
  int          stall_run = 0;

  differential_wrist_transform dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_first_in    (in_first_in),
    .in_second_in   (in_second_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_first_out  (out_first_out),
    .out_second_out (out_second_out),
    .out_was_scaled (out_was_scaled)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gear/joint conversion with the power limit applied in the power modes.
  function automatic wrist_pair_t wrist_transform(input mode_t m, input logic signed [IW-1:0] a,
                                                  input logic signed [IW-1:0] b);
    longint      sa, sb, p, q, peak, unity;
    wrist_pair_t r;
    sa = a;
    sb = b;
    unity = longint'(1) << FRAC_BITS;
    if (m[MODE_J2G_BIT]) begin
      p = sa - sb;
      q = sa + sb;
    end else begin
      p = (sa + sb) >>> 1;
      q = (sb - sa) >>> 1;
    end
    r.scaled = 1'b0;
    if (m[MODE_PWR_BIT]) begin
      peak = (p < 0) ? -p : p;
      if (((q < 0) ? -q : q) > peak) begin
        peak = (q < 0) ? -q : q;
      end
      // Signed division truncates toward zero, which is what the limit requires.
      if (peak > unity) begin
        p = (p * unity) / peak;
        q = (q * unity) / peak;
        r.scaled = 1'b1;
      end
    end
    r.first = p[VW-1:0];
    r.second = q[VW-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 70) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Operands: full-range bits, values around the unit magnitude, and boundary values.
  function automatic int pick_operand();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return $urandom();
    end else if (roll < 85) begin
      return int'($urandom_range(0, 6 * UNITY)) - 3 * UNITY;
    end
    case ($urandom_range(0, 7))
      0: return 0;
      1: return UNITY;
      2: return -UNITY;
      3: return UNITY + 1;
      4: return -UNITY - 1;
      5: return IMAX;
      6: return IMIN;
      default: return -1;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input mode_t m, input int a, input int b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = m;
    in_first_in = a;
    in_second_in = b;
    do @(posedge clk); while (in_stall);
    pending_pairs.push_back(wrist_transform(m, a, b));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    mode_t modes[4];
    int    i;
    modes = '{MODE_G2J_POS, MODE_J2G_POS, MODE_G2J_PWR, MODE_J2G_PWR};
    // Full-scale operands never wrap; position modes never limit.
    for (i = 0; i < 4; i++) begin
      send_item(modes[i], IMAX, IMAX);
      send_item(modes[i], IMIN, IMIN);
      send_item(modes[i], IMAX, IMIN);
      send_item(modes[i], IMIN, IMAX);
    end
    // Odd sums round toward minus infinity.
    send_item(MODE_G2J_POS, -1, 0);
    send_item(MODE_G2J_POS, 0, -1);
    // A magnitude of exactly 1.0 is left alone; one LSB above is limited.
    send_item(MODE_J2G_PWR, UNITY, 0);
    send_item(MODE_G2J_PWR, 2 * UNITY, 0);
    send_item(MODE_J2G_PWR, UNITY, 1);
    send_item(MODE_G2J_PWR, -3, 5);
    send_item(MODE_J2G_PWR, 0, 0);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) begin
      send_item(mode_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
    end
  endtask

  // Power modes with values near the limit, where scaling switches on and off.
  task automatic test_power_limit(input int count);
    mode_t m;
    repeat (count) begin
      m = ($urandom_range(0, 1) != 0) ? MODE_J2G_PWR : MODE_G2J_PWR;
      send_item(m, int'($urandom_range(0, 3 * UNITY)) - UNITY - UNITY / 2,
                int'($urandom_range(0, 3 * UNITY)) - UNITY - UNITY / 2);
    end
  endtask

  task automatic test_drain_pause();
    test_random_mix(40);
    wait_drained();
    test_power_limit(40);
  endtask

  task automatic test_back_to_back(input int count);
    steady_flow = 1'b1;
    test_random_mix(count);
    steady_flow = 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n || steady_flow) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run = stall_run - 1;
    end else if ($urandom_range(0, 99) < 20) begin
      out_stall <= 1'b1;
      stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    wrist_pair_t exp_pair;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result: first_out %0d second_out %0d was_scaled %0b",
               out_first_out, out_second_out, out_was_scaled);
        error_count++;
      end else begin
        exp_pair = pending_pairs.pop_front();
        if (out_first_out !== exp_pair.first) begin
          $error("first_out: expected %0d, got %0d", exp_pair.first, out_first_out);
          error_count++;
        end
        if (out_second_out !== exp_pair.second) begin
          $error("second_out: expected %0d, got %0d", exp_pair.second, out_second_out);
          error_count++;
        end
        if (out_was_scaled !== exp_pair.scaled) begin
          $error("was_scaled: expected %0b, got %0b", exp_pair.scaled, out_was_scaled);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_mix(650);
    test_power_limit(850);
    test_drain_pause();
    test_back_to_back(300);
    wait_drained();
    repeat (NPIPE + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout waiting for transfers");
    $display("== FAIL ==");
    $finish;
  end

endmodule
